// ----- src/axr_pkg.sv -----
// shared types, widths and arithmetic helpers for the x axis alignment rotation block
// no dependencies
package axr_pkg;

  localparam int IN_W      = 16;
  localparam int FRAC      = 14;
  localparam int OUT_W     = 16;
  localparam int ONE       = 1 << FRAC;
  localparam int LG_W      = $clog2(IN_W);
  localparam int SC_TOP    = 29;
  localparam int SC_W      = SC_TOP + 1;
  localparam int SQ_W      = 2 * SC_W;
  localparam int SQ_RAD_W  = SQ_W + 2;
  localparam int SQ_ROOT_W = SQ_RAD_W / 2;
  localparam int SQ_REM_W  = SQ_ROOT_W + 3;
  localparam int SQ_STEPS  = SQ_ROOT_W;
  localparam int DV_Q_W    = FRAC + 2;
  localparam int DV_DEN_W  = SQ_ROOT_W;
  localparam int DV_NUM_W  = DV_DEN_W + DV_Q_W + 1;
  localparam int DV_STEPS  = DV_Q_W;
  localparam int CQ_W      = FRAC + 4;
  localparam int PR_W      = 2 * CQ_W;

  localparam logic signed [CQ_W-1:0] ONE_CQ = CQ_W'(ONE);
  localparam logic [DV_Q_W-1:0] ONE_DQ = DV_Q_W'(ONE);

  typedef enum logic [1:0] {
    ST_ROT  = 2'd0,
    ST_AXIS = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic    nx;
    logic    ny;
    logic    nz;
    status_t st;
  } side_t;

  typedef struct packed {
    logic [SC_W-1:0] sx;
    logic [SC_W-1:0] ty;
    logic [SC_W-1:0] tz;
    logic [LG_W-1:0] diff;
  } pre_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
    status_t                 status;
  } res_t;

  // position of the leading one
  function automatic logic [LG_W-1:0] msb_pos(input logic [IN_W-1:0] v);
    logic [LG_W-1:0] p;
    p = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (v[i]) p = LG_W'(i);
    end
    return p;
  endfunction

  // q-format product, rounded half away from zero on magnitudes
  function automatic logic signed [CQ_W-1:0] qmul(input logic signed [CQ_W-1:0] a,
                                                   input logic signed [CQ_W-1:0] b);
    logic [CQ_W-1:0] ua;
    logic [CQ_W-1:0] ub;
    logic [PR_W-1:0] pr;
    logic [CQ_W-1:0] r;
    ua = a[CQ_W-1] ? CQ_W'(-a) : CQ_W'(a);
    ub = b[CQ_W-1] ? CQ_W'(-b) : CQ_W'(b);
    pr = PR_W'(ua) * PR_W'(ub) + PR_W'(ONE / 2);
    r  = CQ_W'(pr >> FRAC);
    return (a[CQ_W-1] != b[CQ_W-1]) ? $signed(CQ_W'(-r)) : $signed(r);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_one(input logic signed [CQ_W-1:0] v);
    logic signed [CQ_W-1:0] c;
    c = v;
    if (v > ONE_CQ) c = ONE_CQ;
    if (v < -ONE_CQ) c = -ONE_CQ;
    return OUT_W'(c);
  endfunction

endpackage

// ----- src/axr_if.sv -----
// request and result channels of the x axis alignment rotation block
// depends on axr_pkg
interface axr_in_if;
  logic                         valid;
  logic                         ready;
  logic signed [axr_pkg::IN_W-1:0] dir_x;
  logic signed [axr_pkg::IN_W-1:0] dir_y;
  logic signed [axr_pkg::IN_W-1:0] dir_z;
  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface axr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [axr_pkg::OUT_W-1:0] m00;
  logic signed [axr_pkg::OUT_W-1:0] m01;
  logic signed [axr_pkg::OUT_W-1:0] m02;
  logic signed [axr_pkg::OUT_W-1:0] m10;
  logic signed [axr_pkg::OUT_W-1:0] m11;
  logic signed [axr_pkg::OUT_W-1:0] m12;
  logic signed [axr_pkg::OUT_W-1:0] m20;
  logic signed [axr_pkg::OUT_W-1:0] m21;
  logic signed [axr_pkg::OUT_W-1:0] m22;
  axr_pkg::status_t                 status;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, status,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, status,
                output ready);
endinterface

// ----- src/axr_sqrt.sv -----
// pipelined integer square root, one result bit per stage
// depends on axr_pkg
module axr_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [axr_pkg::SQ_RAD_W-1:0]   rad,
  output logic [axr_pkg::SQ_ROOT_W-1:0]  root
);

  logic [axr_pkg::SQ_REM_W-1:0]  rem_r  [axr_pkg::SQ_STEPS-1];
  logic [axr_pkg::SQ_RAD_W-1:0]  rad_r  [axr_pkg::SQ_STEPS-1];
  logic [axr_pkg::SQ_ROOT_W-1:0] root_r [axr_pkg::SQ_STEPS];

  for (genvar j = 0; j < axr_pkg::SQ_STEPS; j++) begin : g_st
    logic [axr_pkg::SQ_REM_W-1:0]  rem_in;
    logic [axr_pkg::SQ_REM_W-1:0]  cur;
    logic [axr_pkg::SQ_REM_W-1:0]  tst;
    logic [axr_pkg::SQ_ROOT_W-1:0] root_in;
    logic [axr_pkg::SQ_RAD_W-1:0]  rad_in;
    logic                          ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign rad_in  = rad_r[j-1];
    end

    assign cur = {rem_in[axr_pkg::SQ_REM_W-3:0], rad_in[axr_pkg::SQ_RAD_W-1 -: 2]};
    assign tst = {1'b0, root_in, 2'b01};
    assign ge  = cur >= tst;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[j] <= {root_in[axr_pkg::SQ_ROOT_W-2:0], ge};
      end
    end

    if (j < axr_pkg::SQ_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? cur - tst : cur;
          rad_r[j] <= rad_in << 2;
        end
      end
    end
  end

  assign root = root_r[axr_pkg::SQ_STEPS-1];

endmodule

// ----- src/axr_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on axr_pkg
module axr_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [axr_pkg::DV_NUM_W-1:0]  num,
  input  logic [axr_pkg::DV_DEN_W-1:0]  den,
  output logic [axr_pkg::DV_Q_W-1:0]    quo
);

  logic [axr_pkg::DV_NUM_W-1:0] rem_r [axr_pkg::DV_STEPS-1];
  logic [axr_pkg::DV_DEN_W-1:0] den_r [axr_pkg::DV_STEPS-1];
  logic [axr_pkg::DV_Q_W-1:0]   q_r   [axr_pkg::DV_STEPS];

  for (genvar j = 0; j < axr_pkg::DV_STEPS; j++) begin : g_st
    logic [axr_pkg::DV_NUM_W-1:0] rem_in;
    logic [axr_pkg::DV_NUM_W-1:0] sh;
    logic [axr_pkg::DV_DEN_W-1:0] den_in;
    logic [axr_pkg::DV_Q_W-1:0]   q_in;
    logic                         ge;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
    end

    assign sh = axr_pkg::DV_NUM_W'(den_in) << (axr_pkg::DV_Q_W - 1 - j);
    assign ge = rem_in >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j] <= {q_in[axr_pkg::DV_Q_W-2:0], ge};
      end
    end

    if (j < axr_pkg::DV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? rem_in - sh : rem_in;
          den_r[j] <= den_in;
        end
      end
    end
  end

  assign quo = q_r[axr_pkg::DV_STEPS-1];

endmodule

// ----- src/align_x_axis_rotation_matrix.sv -----
// channel   dir  payload                          handshake
// in_ch     in   dir_x dir_y dir_z (s16)          valid / ready
// out_ch    out  m00..m22 (s16 q1.14), status     valid / ready
//
// one request per cycle while the skid register is empty; out valid comes from the output register
// most of the latency comes from the 31 stage square root and the 16 stage dividers
// reset is synchronous, active low, and clears valid bits only
// the whole pipeline holds when the skid register is full; nothing is lost
// a result waiting at the output does not block intake for one more request
// top level, depends on axr_pkg, axr_if, axr_sqrt and axr_div
module align_x_axis_rotation_matrix (
  input  logic          clk,
  input  logic          rst_n,
  axr_in_if.sink        in_ch,
  axr_out_if.source     out_ch
);

  localparam int ST_SQ_LAST = 3 + axr_pkg::SQ_STEPS;
  localparam int ST_PREP    = ST_SQ_LAST + 1;
  localparam int ST_DV_LAST = ST_PREP + axr_pkg::DV_STEPS;
  localparam int ST_CL      = ST_DV_LAST + 1;
  localparam int ST_MA      = ST_CL + 1;
  localparam int ST_MB      = ST_MA + 1;
  localparam int DEPTH      = ST_MB + 1;

  logic                en;
  logic                in_fire;
  logic [DEPTH-1:0]    vld_r;
  axr_pkg::side_t      side_r [DEPTH];
  axr_pkg::pre_t       pre_r  [1:ST_SQ_LAST];

  // stage 0
  logic [axr_pkg::IN_W-1:0] mag_x, mag_y, mag_z;
  logic [axr_pkg::IN_W-1:0] mag_x_r, mag_y_r, mag_z_r;
  axr_pkg::side_t           side_in;

  // stage 1
  logic [axr_pkg::IN_W-1:0] mx2, mx3;
  logic [axr_pkg::LG_W-1:0] lg2, lg3;
  logic [axr_pkg::LG_W:0]   k2, k3;
  axr_pkg::pre_t            pre_in;
  logic [axr_pkg::SC_W-1:0] sy_r, sz_r;

  // stages 2 and 3
  logic [axr_pkg::SQ_W-1:0]     sq_x_r, sq_y_r, sq_z_r, sq_ty_r, sq_tz_r;
  logic [axr_pkg::SQ_RAD_W-1:0] sum3_r, sum2_r;

  // square roots and divide prep
  logic [axr_pkg::SQ_ROOT_W-1:0] len3, len2;
  logic [axr_pkg::DV_NUM_W-1:0]  dsh, stot;
  logic [axr_pkg::DV_NUM_W-1:0]  num_c_r, num_p_r, num_q_r, num_s_r;
  logic [axr_pkg::DV_DEN_W-1:0]  den3_r, den2_r;
  logic [axr_pkg::DV_Q_W-1:0]    quo_c, quo_p, quo_q, quo_s;

  // clamp and products
  logic signed [axr_pkg::CQ_W-1:0] c_r, p_r, q_r, s_r;
  logic signed [axr_pkg::CQ_W-1:0] ca_r, pp_r, qq_r, pq_r, ma10_r, ma20_r;
  logic signed [axr_pkg::CQ_W-1:0] m00_r, m10_r, m20_r, m11_r, m22_r, m12_r;

  // output side
  axr_pkg::res_t res, out_r, skid_r;
  logic          out_v_r, skid_v_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;
  assign in_fire     = in_ch.valid && en;

  function automatic logic [axr_pkg::IN_W-1:0] mag_of(input logic signed [axr_pkg::IN_W-1:0] v);
    return v[axr_pkg::IN_W-1] ? axr_pkg::IN_W'(-v) : axr_pkg::IN_W'(v);
  endfunction

  function automatic logic signed [axr_pkg::CQ_W-1:0] clamp_sign(
      input logic neg, input logic [axr_pkg::DV_Q_W-1:0] v);
    logic [axr_pkg::DV_Q_W-1:0] c;
    c = (v > axr_pkg::ONE_DQ) ? axr_pkg::ONE_DQ : v;
    return neg ? $signed(axr_pkg::CQ_W'(-axr_pkg::CQ_W'(c))) : $signed(axr_pkg::CQ_W'(c));
  endfunction

  always_comb begin
    mag_x      = mag_of(in_ch.dir_x);
    mag_y      = mag_of(in_ch.dir_y);
    mag_z      = mag_of(in_ch.dir_z);
    side_in.nx = in_ch.dir_x[axr_pkg::IN_W-1];
    side_in.ny = in_ch.dir_y[axr_pkg::IN_W-1];
    side_in.nz = in_ch.dir_z[axr_pkg::IN_W-1];
    if (mag_y == '0 && mag_z == '0) begin
      side_in.st = (mag_x == '0) ? axr_pkg::ST_ZERO : axr_pkg::ST_AXIS;
    end else begin
      side_in.st = axr_pkg::ST_ROT;
    end
  end

  // prescale so the largest magnitude has its top bit at bit 29
  always_comb begin
    mx2         = (mag_y_r > mag_z_r) ? mag_y_r : mag_z_r;
    mx3         = (mag_x_r > mx2) ? mag_x_r : mx2;
    lg2         = axr_pkg::msb_pos(mx2);
    lg3         = axr_pkg::msb_pos(mx3);
    k2          = (axr_pkg::LG_W + 1)'(axr_pkg::SC_TOP) - (axr_pkg::LG_W + 1)'(lg2);
    k3          = (axr_pkg::LG_W + 1)'(axr_pkg::SC_TOP) - (axr_pkg::LG_W + 1)'(lg3);
    pre_in.sx   = axr_pkg::SC_W'(mag_x_r) << k3;
    pre_in.ty   = axr_pkg::SC_W'(mag_y_r) << k2;
    pre_in.tz   = axr_pkg::SC_W'(mag_z_r) << k2;
    pre_in.diff = lg3 - lg2;
  end

  // valid and sideband
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < DEPTH; i++) begin
        side_r[i] <= side_r[i-1];
      end
      pre_r[1] <= pre_in;
      for (int i = 2; i <= ST_SQ_LAST; i++) begin
        pre_r[i] <= pre_r[i-1];
      end
    end
  end

  // front stages
  always_ff @(posedge clk) begin
    if (en) begin
      mag_x_r <= mag_x;
      mag_y_r <= mag_y;
      mag_z_r <= mag_z;
      sy_r    <= axr_pkg::SC_W'(mag_y_r) << k3;
      sz_r    <= axr_pkg::SC_W'(mag_z_r) << k3;
      sq_x_r  <= axr_pkg::SQ_W'(pre_r[1].sx) * axr_pkg::SQ_W'(pre_r[1].sx);
      sq_y_r  <= axr_pkg::SQ_W'(sy_r) * axr_pkg::SQ_W'(sy_r);
      sq_z_r  <= axr_pkg::SQ_W'(sz_r) * axr_pkg::SQ_W'(sz_r);
      sq_ty_r <= axr_pkg::SQ_W'(pre_r[1].ty) * axr_pkg::SQ_W'(pre_r[1].ty);
      sq_tz_r <= axr_pkg::SQ_W'(pre_r[1].tz) * axr_pkg::SQ_W'(pre_r[1].tz);
      sum3_r  <= axr_pkg::SQ_RAD_W'(sq_x_r) + axr_pkg::SQ_RAD_W'(sq_y_r)
               + axr_pkg::SQ_RAD_W'(sq_z_r);
      sum2_r  <= axr_pkg::SQ_RAD_W'(sq_ty_r) + axr_pkg::SQ_RAD_W'(sq_tz_r);
    end
  end

  axr_sqrt u_sqrt3 (.clk(clk), .en(en), .rad(sum3_r), .root(len3));
  axr_sqrt u_sqrt2 (.clk(clk), .en(en), .rad(sum2_r), .root(len2));

  // rounded quotients: numerator gets half the divisor added
  always_comb begin
    dsh  = axr_pkg::DV_NUM_W'(len3) << pre_r[ST_SQ_LAST].diff;
    stot = (axr_pkg::DV_NUM_W'(len2) << axr_pkg::FRAC) + (dsh >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_c_r <= (axr_pkg::DV_NUM_W'(pre_r[ST_SQ_LAST].sx) << axr_pkg::FRAC)
               + axr_pkg::DV_NUM_W'(len3 >> 1);
      num_p_r <= (axr_pkg::DV_NUM_W'(pre_r[ST_SQ_LAST].ty) << axr_pkg::FRAC)
               + axr_pkg::DV_NUM_W'(len2 >> 1);
      num_q_r <= (axr_pkg::DV_NUM_W'(pre_r[ST_SQ_LAST].tz) << axr_pkg::FRAC)
               + axr_pkg::DV_NUM_W'(len2 >> 1);
      num_s_r <= stot >> pre_r[ST_SQ_LAST].diff;
      den3_r  <= len3;
      den2_r  <= len2;
    end
  end

  axr_div u_div_c (.clk(clk), .en(en), .num(num_c_r), .den(den3_r), .quo(quo_c));
  axr_div u_div_p (.clk(clk), .en(en), .num(num_p_r), .den(den2_r), .quo(quo_p));
  axr_div u_div_q (.clk(clk), .en(en), .num(num_q_r), .den(den2_r), .quo(quo_q));
  axr_div u_div_s (.clk(clk), .en(en), .num(num_s_r), .den(den3_r), .quo(quo_s));

  // clamp, sign and matrix products
  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= clamp_sign(side_r[ST_DV_LAST].nx, quo_c);
      p_r    <= clamp_sign(side_r[ST_DV_LAST].ny, quo_p);
      q_r    <= clamp_sign(side_r[ST_DV_LAST].nz, quo_q);
      s_r    <= clamp_sign(1'b0, quo_s);
      ca_r   <= c_r;
      pp_r   <= axr_pkg::qmul(p_r, p_r);
      qq_r   <= axr_pkg::qmul(q_r, q_r);
      pq_r   <= axr_pkg::qmul(p_r, q_r);
      ma10_r <= axr_pkg::qmul(s_r, p_r);
      ma20_r <= axr_pkg::qmul(s_r, q_r);
      m00_r  <= ca_r;
      m10_r  <= ma10_r;
      m20_r  <= ma20_r;
      m11_r  <= axr_pkg::qmul(ca_r, pp_r) + qq_r;
      m22_r  <= axr_pkg::qmul(ca_r, qq_r) + pp_r;
      m12_r  <= axr_pkg::qmul(ca_r - axr_pkg::ONE_CQ, pq_r);
    end
  end

  always_comb begin
    res.status = side_r[ST_MB].st;
    if (side_r[ST_MB].st == axr_pkg::ST_ROT) begin
      res.m00 = axr_pkg::sat_one(m00_r);
      res.m10 = axr_pkg::sat_one(m10_r);
      res.m20 = axr_pkg::sat_one(m20_r);
      res.m01 = -axr_pkg::sat_one(m10_r);
      res.m02 = -axr_pkg::sat_one(m20_r);
      res.m11 = axr_pkg::sat_one(m11_r);
      res.m22 = axr_pkg::sat_one(m22_r);
      res.m12 = axr_pkg::sat_one(m12_r);
      res.m21 = axr_pkg::sat_one(m12_r);
    end else begin
      res.m00 = axr_pkg::OUT_W'(axr_pkg::ONE);
      res.m11 = axr_pkg::OUT_W'(axr_pkg::ONE);
      res.m22 = axr_pkg::OUT_W'(axr_pkg::ONE);
      res.m01 = '0;
      res.m02 = '0;
      res.m10 = '0;
      res.m12 = '0;
      res.m20 = '0;
      res.m21 = '0;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (en && vld_r[DEPTH-1]) begin
      if (!out_v_r || out_ch.ready) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_ch.ready && out_v_r) begin
      out_v_r  <= skid_v_r;
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[DEPTH-1]) begin
      if (!out_v_r || out_ch.ready) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (out_ch.ready && out_v_r && skid_v_r) begin
      out_r <= skid_r;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.m00    = out_r.m00;
  assign out_ch.m01    = out_r.m01;
  assign out_ch.m02    = out_r.m02;
  assign out_ch.m10    = out_r.m10;
  assign out_ch.m11    = out_r.m11;
  assign out_ch.m12    = out_r.m12;
  assign out_ch.m20    = out_r.m20;
  assign out_ch.m21    = out_r.m21;
  assign out_ch.m22    = out_r.m22;
  assign out_ch.status = out_r.status;

endmodule

// ----- src/axr_chk.sv -----
// port level checks for the x axis alignment rotation block
// depends on axr_pkg; bound to align_x_axis_rotation_matrix
module axr_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [axr_pkg::OUT_W-1:0] m00,
  input logic signed [axr_pkg::OUT_W-1:0] m01,
  input logic signed [axr_pkg::OUT_W-1:0] m02,
  input logic signed [axr_pkg::OUT_W-1:0] m10,
  input logic signed [axr_pkg::OUT_W-1:0] m11,
  input logic signed [axr_pkg::OUT_W-1:0] m12,
  input logic signed [axr_pkg::OUT_W-1:0] m20,
  input logic signed [axr_pkg::OUT_W-1:0] m21,
  input logic signed [axr_pkg::OUT_W-1:0] m22,
  input axr_pkg::status_t                 status
);

  localparam logic signed [axr_pkg::OUT_W-1:0] ONE_O = axr_pkg::OUT_W'(axr_pkg::ONE);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == axr_pkg::ST_ZERO || status == axr_pkg::ST_AXIS) |->
      m00 == ONE_O && m11 == ONE_O && m22 == ONE_O && m01 == '0 && m02 == '0 &&
      m10 == '0 && m12 == '0 && m20 == '0 && m21 == '0)
    else $error("special case is not identity");

  a_skew: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == axr_pkg::ST_ROT |->
      axr_pkg::OUT_W'(m01 + m10) == '0 && axr_pkg::OUT_W'(m02 + m20) == '0)
    else $error("first row and column not antisymmetric");

  a_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == axr_pkg::ST_ROT |-> m12 == m21)
    else $error("m12 and m21 differ");

endmodule

bind align_x_axis_rotation_matrix axr_chk u_axr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .m00       (out_ch.m00),
  .m01       (out_ch.m01),
  .m02       (out_ch.m02),
  .m10       (out_ch.m10),
  .m11       (out_ch.m11),
  .m12       (out_ch.m12),
  .m20       (out_ch.m20),
  .m21       (out_ch.m21),
  .m22       (out_ch.m22),
  .status    (out_ch.status)
);

// ----- test/tb_align_x_axis_rotation_matrix.sv -----
// self-checking bench for the x axis alignment rotation block
// drives directions, takes each Q1.14 matrix and status from the table or predicts it, compares in order
// depends on axr_pkg, axr_if and align_x_axis_rotation_matrix
`timescale 1ns / 100ps

module tb_align_x_axis_rotation_matrix;

  localparam int N_RANDOM   = 1625;
  localparam int QUIET_FROM = 1400;
  localparam int WD_LIMIT   = 4000;
  localparam int TAIL       = 80;

  typedef struct {
    logic signed [axr_pkg::IN_W-1:0] x;
    logic signed [axr_pkg::IN_W-1:0] y;
    logic signed [axr_pkg::IN_W-1:0] z;
    bit                              known;
    axr_pkg::res_t                   want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  axr_in_if  in_ch ();
  axr_out_if out_ch ();

  align_x_axis_rotation_matrix u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  axr_pkg::res_t pending_matrices[$];
  dir_row_t      dir_table[$];
  axr_pkg::res_t typed_matrices[$];
  bit            typed_flags[$];
  int            mismatches;
  int            matrices_seen;
  int            rot_seen, axis_seen, zero_seen;
  int            idle_cycles;
  bit            quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int norm_shift(input logic [63:0] m);
    int lg;
    lg = 0;
    while ((m >> lg) > 1) lg++;
    return 29 - lg;
  endfunction

  function automatic logic [63:0] shifted(input logic [63:0] v, input int k);
    return (k >= 0) ? (v << k) : (v >> (-k));
  endfunction

  function automatic longint clip_one(input longint v);
    if (v > axr_pkg::ONE) return axr_pkg::ONE;
    if (v < -axr_pkg::ONE) return -axr_pkg::ONE;
    return v;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    logic [63:0] ua, ub, r;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    r  = (ua * ub + (64'd1 << (axr_pkg::FRAC - 1))) >> axr_pkg::FRAC;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unit_ratio(input bit neg, input logic [63:0] num,
                                        input logic [63:0] den);
    longint v;
    v = clip_one(longint'(((num << axr_pkg::FRAC) + den / 2) / den));
    return neg ? -v : v;
  endfunction

  function automatic axr_pkg::res_t predict_rotation(input logic signed [axr_pkg::IN_W-1:0] x,
                                                     input logic signed [axr_pkg::IN_W-1:0] y,
                                                     input logic signed [axr_pkg::IN_W-1:0] z);
    logic [63:0] ax, ay, az, mx3, mx2, sx, sy, sz, ty, tz, len3, len2;
    longint m[9];
    longint c, s, p, q, pp, qq, pq;
    int k3, k2, d;
    axr_pkg::res_t r;
    ax = (x < 0) ? 64'(-longint'(x)) : 64'(x);
    ay = (y < 0) ? 64'(-longint'(y)) : 64'(y);
    az = (z < 0) ? 64'(-longint'(z)) : 64'(z);
    for (int i = 0; i < 9; i++) m[i] = 0;
    if (ay == 0 && az == 0) begin
      m[0] = axr_pkg::ONE;
      m[4] = axr_pkg::ONE;
      m[8] = axr_pkg::ONE;
      r.status = (ax == 0) ? axr_pkg::ST_ZERO : axr_pkg::ST_AXIS;
    end else begin
      mx2 = (ay > az) ? ay : az;
      mx3 = (mx2 > ax) ? mx2 : ax;
      k3 = norm_shift(mx3);
      k2 = norm_shift(mx2);
      sx = shifted(ax, k3);
      sy = shifted(ay, k3);
      sz = shifted(az, k3);
      len3 = int_sqrt(sx * sx + sy * sy + sz * sz);
      ty = shifted(ay, k2);
      tz = shifted(az, k2);
      len2 = int_sqrt(ty * ty + tz * tz);
      c = unit_ratio(x < 0, sx, len3);
      p = unit_ratio(y < 0, ty, len2);
      q = unit_ratio(z < 0, tz, len2);
      d = k2 - k3;
      s = (d > 32) ? 0 : unit_ratio(1'b0, len2, len3 << d);
      pp = fx_mul(p, p);
      qq = fx_mul(q, q);
      pq = fx_mul(p, q);
      m[0] = c;
      m[3] = fx_mul(s, p);
      m[6] = fx_mul(s, q);
      m[1] = -m[3];
      m[2] = -m[6];
      m[4] = fx_mul(c, pp) + qq;
      m[8] = fx_mul(c, qq) + pp;
      m[5] = fx_mul(c - axr_pkg::ONE, pq);
      m[7] = m[5];
      r.status = axr_pkg::ST_ROT;
    end
    r.m00 = axr_pkg::OUT_W'(clip_one(m[0]));
    r.m01 = axr_pkg::OUT_W'(clip_one(m[1]));
    r.m02 = axr_pkg::OUT_W'(clip_one(m[2]));
    r.m10 = axr_pkg::OUT_W'(clip_one(m[3]));
    r.m11 = axr_pkg::OUT_W'(clip_one(m[4]));
    r.m12 = axr_pkg::OUT_W'(clip_one(m[5]));
    r.m20 = axr_pkg::OUT_W'(clip_one(m[6]));
    r.m21 = axr_pkg::OUT_W'(clip_one(m[7]));
    r.m22 = axr_pkg::OUT_W'(clip_one(m[8]));
    return r;
  endfunction

  function automatic axr_pkg::res_t identity(input axr_pkg::status_t st);
    axr_pkg::res_t r;
    r = '0;
    r.m00 = axr_pkg::OUT_W'(axr_pkg::ONE);
    r.m11 = axr_pkg::OUT_W'(axr_pkg::ONE);
    r.m22 = axr_pkg::OUT_W'(axr_pkg::ONE);
    r.status = st;
    return r;
  endfunction

  function automatic void add_row(input int x, input int y, input int z, input bit known,
                                  input axr_pkg::res_t want);
    dir_row_t row;
    row.x = axr_pkg::IN_W'(x);
    row.y = axr_pkg::IN_W'(y);
    row.z = axr_pkg::IN_W'(z);
    row.known = known;
    row.want = want;
    dir_table.push_back(row);
  endfunction

  task automatic pick_random(output dir_row_t row);
    int kind;
    kind = $urandom_range(0, 9);
    row.known = 1'b0;
    row.want = '0;
    row.x = axr_pkg::IN_W'($urandom);
    row.y = axr_pkg::IN_W'($urandom);
    row.z = axr_pkg::IN_W'($urandom);
    case (kind)
      0: begin
        row.y = '0;
        row.z = '0;
      end
      1: begin
        row.x = axr_pkg::IN_W'(int'($urandom_range(0, 6)) - 3);
        row.y = axr_pkg::IN_W'(int'($urandom_range(0, 6)) - 3);
        row.z = axr_pkg::IN_W'(int'($urandom_range(0, 6)) - 3);
      end
      2: row.y = axr_pkg::IN_W'(int'($urandom_range(0, 2)) - 1);
      3: row.z = '0;
      4: row.x = '0;
      5: begin
        row.y = axr_pkg::IN_W'(int'($urandom_range(0, 6)) - 3);
        row.z = axr_pkg::IN_W'(int'($urandom_range(0, 6)) - 3);
      end
      default: ;
    endcase
  endtask

  task automatic send_dir(input dir_row_t row);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.dir_x <= row.x;
    in_ch.dir_y <= row.y;
    in_ch.dir_z <= row.z;
    typed_flags.push_back(row.known);
    typed_matrices.push_back(row.want);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // intake monitor: on every accepted request, queue the table's matrix or a predicted one
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (typed_flags.pop_front())
        pending_matrices.push_back(typed_matrices.pop_front());
      else begin
        void'(typed_matrices.pop_front());
        pending_matrices.push_back(predict_rotation(in_ch.dir_x, in_ch.dir_y,
                                                    in_ch.dir_z));
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    axr_pkg::res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.m00 = out_ch.m00;
      got.m01 = out_ch.m01;
      got.m02 = out_ch.m02;
      got.m10 = out_ch.m10;
      got.m11 = out_ch.m11;
      got.m12 = out_ch.m12;
      got.m20 = out_ch.m20;
      got.m21 = out_ch.m21;
      got.m22 = out_ch.m22;
      got.status = out_ch.status;
      matrices_seen++;
      case (got.status)
        axr_pkg::ST_ROT:  rot_seen++;
        axr_pkg::ST_AXIS: axis_seen++;
        default: zero_seen++;
      endcase
      if (pending_matrices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected matrix %p", got);
      end else begin
        want = pending_matrices.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("matrix %0d mismatch: expected %p got %p", matrices_seen, want, got);
        end
      end
    end
  end

  // result side back pressure
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 4);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("timeout waiting for a request");
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    int waited;
    mismatches = 0;
    matrices_seen = 0;
    rot_seen = 0;
    axis_seen = 0;
    zero_seen = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.dir_x = '0;
    in_ch.dir_y = '0;
    in_ch.dir_z = '0;

    add_row(0, 0, 0, 1, identity(axr_pkg::ST_ZERO));
    add_row(1, 0, 0, 1, identity(axr_pkg::ST_AXIS));
    add_row(-1, 0, 0, 1, identity(axr_pkg::ST_AXIS));
    add_row(32767, 0, 0, 1, identity(axr_pkg::ST_AXIS));
    add_row(-32768, 0, 0, 1, identity(axr_pkg::ST_AXIS));
    add_row(0, 1, 0, 0, '0);
    add_row(0, 0, 1, 0, '0);
    add_row(0, -32768, 0, 0, '0);
    add_row(0, 0, -32768, 0, '0);
    add_row(0, 32767, 32767, 0, '0);
    add_row(32767, 32767, 32767, 0, '0);
    add_row(-32768, -32768, -32768, 0, '0);
    add_row(32767, -32768, 1, 0, '0);
    add_row(-32768, 1, 0, 0, '0);
    add_row(32767, 0, -1, 0, '0);
    add_row(1, 1, 1, 0, '0);
    add_row(-1, 0, 1, 0, '0);
    add_row(1, 32767, 0, 0, '0);
    add_row(-1, -1, -1, 0, '0);
    add_row(0, -1, 1, 0, '0);
    add_row(100, -200, 300, 0, '0);
    add_row(-21845, 10922, -5461, 0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) send_dir(dir_table[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_matrices.size() != 0) @(posedge clk);
      end
      if (i == QUIET_FROM) quiet = 1'b1;
      pick_random(row);
      send_dir(row);
    end
    in_ch.valid <= 1'b0;

    while (pending_matrices.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < TAIL) begin
      @(posedge clk);
      waited++;
    end

    $display("%0d matrices checked: %0d rotations, %0d on the x axis, %0d zero vectors",
             matrices_seen, rot_seen, axis_seen, zero_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && pending_matrices.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/axr_pkg.sv
src/axr_if.sv
src/axr_sqrt.sv
src/axr_div.sv
src/align_x_axis_rotation_matrix.sv
src/axr_chk.sv
test/tb_align_x_axis_rotation_matrix.sv
